>>> hw/rtl/banked_ram_window_macros.svh
// assertion macros shared by the banked ram window rtl
// needs a clk and an active-low rst_n in the scope of use
`ifndef BANKED_RAM_WINDOW_MACROS_SVH
`define BANKED_RAM_WINDOW_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BRW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define BRW_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/brw_pkg.sv
// types, constants and helpers for the banked ram window
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brw_pkg;

    localparam int unsigned WIN_W   = 10;
    localparam int unsigned LATCH_W = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned FULL_W  = LATCH_W + WIN_W;
    localparam int unsigned DATA_W  = 8;

    localparam int unsigned DEF_LOW_CARD_BANKS  = 16;
    localparam int unsigned DEF_HIGH_CARD_BANKS = 16;
    localparam int unsigned DEF_LATCH_OFFSET    = 1023;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_LOW_ACTIVE  = 1'b0;
    localparam cfg_index_t REG_HIGH_ACTIVE = 1'b1;

    typedef enum logic [0:0] {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } brw_state_t;

    // requested count clamped to 1..fitted, rounded down to a power of two, minus one
    function automatic logic [LATCH_W-1:0] eff_mask(input logic [COUNT_W-1:0] request,
                                                    input logic [COUNT_W-1:0] fitted);
        logic [COUNT_W-1:0] n;
        logic [COUNT_W-1:0] p;
        n = (request > fitted) ? fitted : request;
        if (n == '0)
            n = COUNT_W'(1);
        p = COUNT_W'(1);
        for (int i = 0; i < COUNT_W; i++)
        begin
            if (n[i])
                p = COUNT_W'(1) << i;
        end
        return LATCH_W'(p - COUNT_W'(1));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/banked_ram_window.sv
// reads: a read item's byte is offered in the cycle after acceptance
// throughput: one item per cycle when not clearing or held off, set by the single port of each card store
// writes give no result; an unread result holds off further items
// after reset each store is cleared one byte a cycle over max(larger fitted count, 1) * 1024
// addresses (16384 by default), no items taken meanwhile; config writes always taken
// rst_n is asynchronous: clears latches, valid and state, sets masks from the fitted counts
`timescale 1ns / 1ps
`default_nettype none

module banked_ram_window #(
    parameter int unsigned LOW_CARD_BANKS  = brw_pkg::DEF_LOW_CARD_BANKS,
    parameter int unsigned HIGH_CARD_BANKS = brw_pkg::DEF_HIGH_CARD_BANKS,
    parameter int unsigned LATCH_OFFSET    = brw_pkg::DEF_LATCH_OFFSET
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         req_type,
    input  wire logic                         card_sel,
    input  wire logic [brw_pkg::WIN_W-1:0]    window_offset,
    input  wire logic [brw_pkg::DATA_W-1:0]   write_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [brw_pkg::DATA_W-1:0]        read_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire brw_pkg::cfg_index_t          cfg_index,
    input  wire logic [brw_pkg::COUNT_W-1:0]  cfg_data
);
    import brw_pkg::*;

    localparam int unsigned WIN_BYTES  = 1 << WIN_W;
    localparam int unsigned LOW_DEPTH  = ((LOW_CARD_BANKS > 0) ? LOW_CARD_BANKS : 1) * WIN_BYTES;
    localparam int unsigned HIGH_DEPTH = ((HIGH_CARD_BANKS > 0) ? HIGH_CARD_BANKS : 1) * WIN_BYTES;
    localparam int unsigned MAX_DEPTH  = (LOW_DEPTH > HIGH_DEPTH) ? LOW_DEPTH : HIGH_DEPTH;
    localparam int unsigned LOW_AW     = $clog2(LOW_DEPTH);
    localparam int unsigned HIGH_AW    = $clog2(HIGH_DEPTH);
    localparam int unsigned CLR_W      = $clog2(MAX_DEPTH);
    localparam bit          LOW_FITTED  = (LOW_CARD_BANKS > 0);
    localparam bit          HIGH_FITTED = (HIGH_CARD_BANKS > 0);
    localparam logic [COUNT_W-1:0] LOW_FIT_CNT  = COUNT_W'(LOW_CARD_BANKS);
    localparam logic [COUNT_W-1:0] HIGH_FIT_CNT = COUNT_W'(HIGH_CARD_BANKS);
    localparam logic [LATCH_W-1:0] LOW_MASK_RST  = eff_mask(LOW_FIT_CNT, LOW_FIT_CNT);
    localparam logic [LATCH_W-1:0] HIGH_MASK_RST = eff_mask(HIGH_FIT_CNT, HIGH_FIT_CNT);

    brw_state_t state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [LATCH_W-1:0] low_latch_reg, low_latch_next;
    logic [LATCH_W-1:0] high_latch_reg, high_latch_next;
    logic [LATCH_W-1:0] low_mask_reg, low_mask_next;
    logic [LATCH_W-1:0] high_mask_reg, high_mask_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_card_reg, out_card_next;

    logic [DATA_W-1:0] low_mem  [LOW_DEPTH];
    logic [DATA_W-1:0] high_mem [HIGH_DEPTH];
    logic [DATA_W-1:0] low_rd_q, high_rd_q;

    logic               clearing;
    logic               clr_last;
    logic               accept;
    logic               at_latch;
    logic [LATCH_W-1:0] latch_src;
    logic [LATCH_W-1:0] bank;
    logic [FULL_W-1:0]  acc_addr;
    logic               low_we, high_we, low_re, high_re;
    logic [LOW_AW-1:0]  low_addr;
    logic [HIGH_AW-1:0] high_addr;
    logic [DATA_W-1:0]  wr_byte;

    // ---------------- state machine ----------------
    assign clr_last = (clr_cnt_reg == CLR_W'(MAX_DEPTH - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_last) state_next = ST_RUN;
            ST_RUN:   state_next = ST_RUN;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        clearing = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    assign clr_cnt_next = clearing ? clr_cnt_reg + CLR_W'(1) : clr_cnt_reg;

    // ---------------- handshake ----------------
    assign in_ready  = !clearing && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ---------------- address ----------------
    assign at_latch  = (window_offset == WIN_W'(LATCH_OFFSET));
    // a latch-offset write maps through the new latch value
    assign latch_src = card_sel ? ((req_type && at_latch) ? write_data : high_latch_reg)
                                : ((req_type && at_latch) ? write_data : low_latch_reg);
    assign bank      = latch_src & (card_sel ? high_mask_reg : low_mask_reg);
    assign acc_addr  = {bank, window_offset};

    always_comb
    begin
        low_latch_next  = low_latch_reg;
        high_latch_next = high_latch_reg;
        if (accept && req_type && at_latch)
        begin
            if (card_sel && HIGH_FITTED)
                high_latch_next = write_data;
            else if (!card_sel && LOW_FITTED)
                low_latch_next = write_data;
        end
    end

    always_comb
    begin
        low_mask_next  = low_mask_reg;
        high_mask_next = high_mask_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOW_ACTIVE:  low_mask_next  = eff_mask(cfg_data, LOW_FIT_CNT);
                REG_HIGH_ACTIVE: high_mask_next = eff_mask(cfg_data, HIGH_FIT_CNT);
                default:         ;
            endcase
        end
    end

    // ---------------- store access ----------------
    assign wr_byte  = clearing ? '0 : write_data;
    assign low_we   = clearing ? ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(LOW_DEPTH))
                               : (accept && req_type && !card_sel && LOW_FITTED);
    assign high_we  = clearing ? ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(HIGH_DEPTH))
                               : (accept && req_type && card_sel && HIGH_FITTED);
    assign low_re   = accept && !req_type && !card_sel && LOW_FITTED;
    assign high_re  = accept && !req_type && card_sel && HIGH_FITTED;
    assign low_addr  = clearing ? LOW_AW'(clr_cnt_reg) : LOW_AW'(acc_addr);
    assign high_addr = clearing ? HIGH_AW'(clr_cnt_reg) : HIGH_AW'(acc_addr);

    always_ff @(posedge clk)
    begin
        if (low_we)
            low_mem[low_addr] <= wr_byte;
        if (low_re)
            low_rd_q <= low_mem[low_addr];
    end

    always_ff @(posedge clk)
    begin
        if (high_we)
            high_mem[high_addr] <= wr_byte;
        if (high_re)
            high_rd_q <= high_mem[high_addr];
    end

    // ---------------- result ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_card_next  = out_card_reg;
        if (accept && !req_type)
        begin
            out_valid_next = 1'b1;
            out_card_next  = card_sel;
        end
    end

    assign out_valid = out_valid_reg;
    // empty slot reads as zero
    assign read_data = out_card_reg ? (HIGH_FITTED ? high_rd_q : '0)
                                    : (LOW_FITTED ? low_rd_q : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            low_latch_reg  <= '0;
            high_latch_reg <= '0;
            low_mask_reg   <= LOW_MASK_RST;
            high_mask_reg  <= HIGH_MASK_RST;
            out_valid_reg  <= 1'b0;
            out_card_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            low_latch_reg  <= low_latch_next;
            high_latch_reg <= high_latch_next;
            low_mask_reg   <= low_mask_next;
            high_mask_reg  <= high_mask_next;
            out_valid_reg  <= out_valid_next;
            out_card_reg   <= out_card_next;
        end
    end

    // ---------------- checks ----------------
    `include "banked_ram_window_macros.svh"

    `BRW_ASSERT(a_no_item_in_clear, !(accept && state_reg == ST_CLEAR), "item taken while clearing")
    `BRW_ASSERT(a_no_result_in_clear, !(out_valid_reg && state_reg == ST_CLEAR), "result during clear")
    `BRW_ASSERT_NEXT(a_read_gives_result, accept && !req_type, out_valid_reg, "read item lost")
    `BRW_ASSERT_NEXT(a_write_no_result, accept && req_type && !out_valid_reg, !out_valid_reg, "write item made a result")
    `BRW_ASSERT_NEXT(a_low_latch_load, accept && req_type && at_latch && !card_sel && LOW_FITTED, low_latch_reg == $past(write_data), "low latch not loaded")

endmodule

`default_nettype wire
